// ===== sv/hrhp_pkg.sv =====
// Shared types and constants for the HTTP request header parser.
// Depends on nothing; used by hrhp_token_decode and http_request_header_parser_core.
package hrhp_pkg;

    // Width of every offset and length field on the result channel.
    localparam int FIELD_W = 13;

    // Default head size; offsets and lengths saturate one below it.
    localparam int MAX_HEAD_BYTES_DEF = 8192;

    // Reset value of the header limit register.
    localparam logic [7:0] MAX_HEADERS_RST = 8'd64;

    // A header line this short or shorter terminates the head.
    localparam int END_LINE_MAX = 4;

    // Byte codes the parser reacts to.
    localparam logic [7:0] BYTE_CR    = 8'h0D;
    localparam logic [7:0] BYTE_SPACE = 8'h20;
    localparam logic [7:0] BYTE_COLON = 8'h3A;

    // Result kinds.
    localparam logic [1:0] KIND_REQ_LINE = 2'd0;
    localparam logic [1:0] KIND_HEADER   = 2'd1;
    localparam logic [1:0] KIND_END      = 2'd2;
    localparam logic [1:0] KIND_ERROR    = 2'd3;

    // Error codes.
    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_NO_TOKEN   = 2'd1;
    localparam logic [1:0] ERR_NO_COLON   = 2'd2;
    localparam logic [1:0] ERR_TOO_MANY   = 2'd3;

    // Method and version codes.
    localparam logic [3:0] METHOD_UNKNOWN = 4'd8;
    localparam logic       VERSION_11     = 1'b0;
    localparam logic       VERSION_OTHER  = 1'b1;

    // Method names packed right-aligned, most significant byte first.
    localparam logic [55:0] METHOD_PACK [8] = '{
        56'h474554,          // GET
        56'h48454144,        // HEAD
        56'h504F5354,        // POST
        56'h505554,          // PUT
        56'h44454C455445,    // DELETE
        56'h434F4E4E454354,  // CONNECT
        56'h4F5054494F4E53,  // OPTIONS
        56'h5452414345       // TRACE
    };
    localparam logic [3:0] METHOD_LEN [8] = '{
        4'd3, 4'd4, 4'd4, 4'd3, 4'd6, 4'd7, 4'd7, 4'd5
    };
    localparam logic [63:0] VERSION_PACK = 64'h485454502F312E31;  // HTTP/1.1
    localparam logic [3:0]  VERSION_LEN  = 4'd8;

    // Parser phase.
    typedef enum logic [1:0] {
        PH_REQ,
        PH_HDR,
        PH_DONE
    } phase_t;

    // One input byte.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       start_request;
    } in_item_t;

    // One parse result.
    typedef struct packed {
        logic [1:0]         kind;
        logic [3:0]         method_code;
        logic               version_code;
        logic [FIELD_W-1:0] first_start;
        logic [FIELD_W-1:0] first_length;
        logic [FIELD_W-1:0] second_start;
        logic [FIELD_W-1:0] second_length;
        logic [7:0]         header_index;
        logic [1:0]         error_code;
    } out_item_t;

endpackage

// ===== sv/hrhp_token_decode.sv =====
// Decodes the accumulated method and version tokens of the request line.
// Depends on hrhp_pkg for the name tables.
module hrhp_token_decode (
    input  logic [55:0] method_accum,
    input  logic [3:0]  method_len,
    input  logic [63:0] version_accum,
    input  logic [3:0]  version_len,
    output logic [3:0]  method_code,
    output logic        version_code
);
    import hrhp_pkg::*;

    // Compare against all eight names in parallel; names are distinct,
    // so at most one matches.
    always_comb begin
        method_code = METHOD_UNKNOWN;
        for (int i = 7; i >= 0; i--) begin
            if (method_len == METHOD_LEN[i] && method_accum == METHOD_PACK[i]) begin
                method_code = 4'(i);
            end
        end
    end

    // The version must be exactly the eight bytes of HTTP/1.1.
    assign version_code = (version_len == VERSION_LEN && version_accum == VERSION_PACK)
                          ? VERSION_11 : VERSION_OTHER;

endmodule

// ===== sv/http_request_header_parser_core.sv =====
// Top level of the HTTP request header parser: byte stream in, parse results out.
// Depends on hrhp_pkg and hrhp_token_decode.

// The parser takes one byte of a request head per transfer and gives at most one
// result per byte: the request line (method, version, route offset and length) at
// its carriage return, each header (key and value offsets and lengths) at its
// carriage return, then an end-of-headers result or an error. Every byte is parsed
// combinationally by parallel compares on the parser state, so a byte can be
// taken every cycle; the only stall comes from the result register, which accepts
// a new byte whenever it is empty or being drained in the same cycle. A byte with
// start_request set clears the parser and is parsed at offset 0. After an end or
// error result, bytes are consumed silently until the next start_request. Offsets
// and lengths saturate at MAX_HEAD_BYTES-1 and are reported in their low 13 bits. The
// user must write max_headers via cfg_we and cfg_wdata only while idle (not enforced).
module http_request_header_parser_core #(
    parameter int MAX_HEAD_BYTES = hrhp_pkg::MAX_HEAD_BYTES_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    input  logic                s_valid,
    output logic                s_ready,
    input  hrhp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hrhp_pkg::out_item_t m_data
);
    import hrhp_pkg::*;

    localparam int OFS_W = $clog2(MAX_HEAD_BYTES);
    localparam logic [OFS_W-1:0] SAT_MAX = OFS_W'(MAX_HEAD_BYTES - 1);

    // Saturating increment shared by every offset and length.
    function automatic logic [OFS_W-1:0] sat_inc(input logic [OFS_W-1:0] v);
        return (v < SAT_MAX) ? v + OFS_W'(1) : SAT_MAX;
    endfunction

    // Fit an internal offset into the 13-bit result field.
    function automatic logic [FIELD_W-1:0] to_field(input logic [OFS_W-1:0] v);
        logic [OFS_W+FIELD_W-1:0] w;
        w = {{FIELD_W{1'b0}}, v};
        return w[FIELD_W-1:0];
    endfunction

    // Registers.
    logic [7:0]       max_headers_reg;
    phase_t           phase_reg, phase_next;
    logic [OFS_W-1:0] byte_offset_reg, byte_offset_next;
    logic [OFS_W-1:0] line_start_reg, line_start_next;
    logic [55:0]      method_accum_reg, method_accum_next;
    logic [3:0]       method_len_reg, method_len_next;
    logic [63:0]      version_accum_reg, version_accum_next;
    logic [3:0]       version_len_reg, version_len_next;
    logic [2:0]       token_count_reg, token_count_next;
    logic             in_token_reg, in_token_next;
    logic [3:0]       held_method_reg, held_method_next;
    logic [OFS_W-1:0] route_start_reg, route_start_next;
    logic [OFS_W-1:0] route_length_reg, route_length_next;
    logic [OFS_W-1:0] line_len_reg, line_len_next;
    logic [OFS_W-1:0] key_length_reg, key_length_next;
    logic [OFS_W-1:0] val_len_reg, val_len_next;
    logic             colon_seen_reg, colon_seen_next;
    logic [1:0]       skip_left_reg, skip_left_next;
    logic             line_begun_reg, line_begun_next;
    logic [7:0]       headers_seen_reg, headers_seen_next;
    logic             m_valid_reg, m_valid_next;
    out_item_t        m_data_reg, m_data_next;

    // State as seen by this byte, after an optional clear.
    logic             clr;
    phase_t           ph;
    logic [OFS_W-1:0] ofs, line_start, route_start, route_length;
    logic [OFS_W-1:0] line_len, key_length, val_len;
    logic [55:0]      method_accum;
    logic [63:0]      version_accum;
    logic [3:0]       method_len, version_len, held_method;
    logic [2:0]       token_count;
    logic             in_token, colon_seen, line_begun;
    logic [1:0]       skip_left;
    logic [7:0]       headers_seen;

    logic [7:0]       b;
    logic             is_cr, is_space, is_colon;
    logic             accept;
    logic             req_end, req_err;
    logic             hdr_begin, hdr_end, end_head, too_many, no_colon, hdr_ok;
    logic             emit;
    logic [3:0]       dec_method;
    logic             dec_version;
    logic [2:0]       tc_new;
    logic             tok_open;
    logic [OFS_W-1:0] route_base;
    logic [OFS_W-1:0] vstart;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // Apply start_request as a clear of the working state.
    assign clr           = s_data.start_request;
    assign b             = s_data.data_byte;
    assign ph            = clr ? PH_REQ : phase_reg;
    assign ofs           = clr ? '0 : byte_offset_reg;
    assign line_start    = clr ? '0 : line_start_reg;
    assign method_accum  = clr ? '0 : method_accum_reg;
    assign method_len    = clr ? '0 : method_len_reg;
    assign version_accum = clr ? '0 : version_accum_reg;
    assign version_len   = clr ? '0 : version_len_reg;
    assign token_count   = clr ? '0 : token_count_reg;
    assign in_token      = clr ? 1'b0 : in_token_reg;
    assign held_method   = clr ? '0 : held_method_reg;
    assign route_start   = clr ? '0 : route_start_reg;
    assign route_length  = clr ? '0 : route_length_reg;
    assign line_len      = clr ? '0 : line_len_reg;
    assign key_length    = clr ? '0 : key_length_reg;
    assign val_len       = clr ? '0 : val_len_reg;
    assign colon_seen    = clr ? 1'b0 : colon_seen_reg;
    assign skip_left     = clr ? '0 : skip_left_reg;
    assign line_begun    = clr ? 1'b0 : line_begun_reg;
    assign headers_seen  = clr ? '0 : headers_seen_reg;

    // Byte class and line events.
    assign is_cr    = (b == BYTE_CR);
    assign is_space = (b == BYTE_SPACE);
    assign is_colon = (b == BYTE_COLON);

    assign req_end   = (ph == PH_REQ) && is_cr && (line_len != '0);
    assign req_err   = req_end && (token_count < 3'd3);
    assign hdr_begin = (ph == PH_HDR) && !line_begun && !is_cr;
    assign hdr_end   = (ph == PH_HDR) && line_begun && is_cr;
    assign end_head  = hdr_end && (line_len <= OFS_W'(END_LINE_MAX));
    assign too_many  = hdr_end && !end_head && (headers_seen >= max_headers_reg);
    assign no_colon  = hdr_end && !end_head && !too_many && !colon_seen;
    assign hdr_ok    = hdr_end && !end_head && !too_many && colon_seen;
    assign emit      = req_end || hdr_end;

    // Token bookkeeping for a non-separator byte on the request line.
    assign tok_open   = !in_token;
    assign tc_new     = (tok_open && token_count < 3'd4) ? token_count + 3'd1 : token_count;
    assign route_base = (tok_open && tc_new == 3'd2) ? '0 : route_length;
    assign vstart     = (val_len <= ofs) ? ofs - val_len : '0;

    hrhp_token_decode u_decode (
        .method_accum  (method_accum),
        .method_len    (method_len),
        .version_accum (version_accum),
        .version_len   (version_len),
        .method_code   (dec_method),
        .version_code  (dec_version)
    );

    // Next phase.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            unique case (ph)
                PH_REQ: begin
                    if (req_err) begin
                        phase_next = PH_DONE;
                    end else if (req_end) begin
                        phase_next = PH_HDR;
                    end else begin
                        phase_next = PH_REQ;
                    end
                end
                PH_HDR: begin
                    phase_next = (hdr_end && !hdr_ok) ? PH_DONE : PH_HDR;
                end
                PH_DONE: begin
                    phase_next = PH_DONE;
                end
                default: begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    // Datapath state and result for the accepted byte.
    always_comb begin
        byte_offset_next   = byte_offset_reg;
        line_start_next    = line_start_reg;
        method_accum_next  = method_accum_reg;
        method_len_next    = method_len_reg;
        version_accum_next = version_accum_reg;
        version_len_next   = version_len_reg;
        token_count_next   = token_count_reg;
        in_token_next      = in_token_reg;
        held_method_next   = held_method_reg;
        route_start_next   = route_start_reg;
        route_length_next  = route_length_reg;
        line_len_next      = line_len_reg;
        key_length_next    = key_length_reg;
        val_len_next       = val_len_reg;
        colon_seen_next    = colon_seen_reg;
        skip_left_next     = skip_left_reg;
        line_begun_next    = line_begun_reg;
        headers_seen_next  = headers_seen_reg;
        m_data_next        = '0;
        m_valid_next       = m_valid_reg && !m_ready;

        if (accept) begin
            byte_offset_next   = sat_inc(ofs);
            line_start_next    = line_start;
            method_accum_next  = method_accum;
            method_len_next    = method_len;
            version_accum_next = version_accum;
            version_len_next   = version_len;
            token_count_next   = token_count;
            in_token_next      = in_token;
            held_method_next   = held_method;
            route_start_next   = route_start;
            route_length_next  = route_length;
            line_len_next      = line_len;
            key_length_next    = key_length;
            val_len_next       = val_len;
            colon_seen_next    = colon_seen;
            skip_left_next     = skip_left;
            line_begun_next    = line_begun;
            headers_seen_next  = headers_seen;

            case (ph)
                PH_REQ: begin
                    if (is_cr) begin
                        // End of the request line; a leading CR is skipped.
                        if (req_end) begin
                            if (in_token && token_count == 3'd1) begin
                                held_method_next = dec_method;
                            end
                            line_begun_next = 1'b0;
                        end
                    end else begin
                        line_len_next = sat_inc(line_len);
                        if (is_space) begin
                            if (in_token && token_count == 3'd1) begin
                                held_method_next = dec_method;
                            end
                            in_token_next = 1'b0;
                        end else begin
                            in_token_next    = 1'b1;
                            token_count_next = tc_new;
                            if (tok_open && tc_new == 3'd2) begin
                                route_start_next = ofs;
                            end
                            // Collect the byte into the current token.
                            if (tc_new == 3'd1) begin
                                if (method_len < 4'd7) begin
                                    method_accum_next = {method_accum[47:0], b};
                                end
                                if (method_len < 4'd8) begin
                                    method_len_next = method_len + 4'd1;
                                end
                            end else if (tc_new == 3'd2) begin
                                route_length_next = sat_inc(route_base);
                            end else if (tc_new == 3'd3) begin
                                if (version_len < 4'd8) begin
                                    version_accum_next = {version_accum[55:0], b};
                                end
                                if (version_len < 4'd9) begin
                                    version_len_next = version_len + 4'd1;
                                end
                            end
                        end
                    end
                end
                PH_HDR: begin
                    if (hdr_begin) begin
                        // The first non-CR byte, normally the line feed, opens a new line.
                        line_begun_next = 1'b1;
                        line_start_next = sat_inc(ofs);
                        line_len_next   = '0;
                        key_length_next = '0;
                        val_len_next    = '0;
                        colon_seen_next = 1'b0;
                        skip_left_next  = '0;
                    end else if (hdr_end) begin
                        line_begun_next = 1'b0;
                        if (hdr_ok && headers_seen < 8'd255) begin
                            headers_seen_next = headers_seen + 8'd1;
                        end
                    end else if (line_begun) begin
                        line_len_next = sat_inc(line_len);
                        if (!colon_seen) begin
                            if (is_colon) begin
                                colon_seen_next = 1'b1;
                                skip_left_next  = 2'd2;
                            end else begin
                                key_length_next = sat_inc(key_length);
                            end
                        end else if (skip_left != 2'd0) begin
                            skip_left_next = skip_left - 2'd1;
                        end else begin
                            val_len_next = sat_inc(val_len);
                        end
                    end
                end
                default: begin
                    // Done: bytes are consumed until the next start_request.
                end
            endcase

            // Build the result for this byte.
            if (req_err) begin
                m_data_next.kind       = KIND_ERROR;
                m_data_next.error_code = ERR_NO_TOKEN;
            end else if (req_end) begin
                m_data_next.kind         = KIND_REQ_LINE;
                m_data_next.method_code  = held_method;
                m_data_next.version_code = dec_version;
                m_data_next.first_start  = to_field(route_start);
                m_data_next.first_length = to_field(route_length);
            end else if (end_head) begin
                m_data_next.kind         = KIND_END;
                m_data_next.header_index = headers_seen;
            end else if (too_many) begin
                m_data_next.kind       = KIND_ERROR;
                m_data_next.error_code = ERR_TOO_MANY;
            end else if (no_colon) begin
                m_data_next.kind       = KIND_ERROR;
                m_data_next.error_code = ERR_NO_COLON;
            end else if (hdr_ok) begin
                m_data_next.kind          = KIND_HEADER;
                m_data_next.first_start   = to_field(line_start);
                m_data_next.first_length  = to_field(key_length);
                m_data_next.second_start  = to_field(vstart);
                m_data_next.second_length = to_field(val_len);
                m_data_next.header_index  = headers_seen;
            end
            if (emit) begin
                m_valid_next = 1'b1;
            end
        end
    end

    // Parser state, configuration and result valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_headers_reg   <= MAX_HEADERS_RST;
            phase_reg         <= PH_REQ;
            byte_offset_reg   <= '0;
            line_start_reg    <= '0;
            method_accum_reg  <= '0;
            method_len_reg    <= '0;
            version_accum_reg <= '0;
            version_len_reg   <= '0;
            token_count_reg   <= '0;
            in_token_reg      <= 1'b0;
            held_method_reg   <= '0;
            route_start_reg   <= '0;
            route_length_reg  <= '0;
            line_len_reg      <= '0;
            key_length_reg    <= '0;
            val_len_reg       <= '0;
            colon_seen_reg    <= 1'b0;
            skip_left_reg     <= '0;
            line_begun_reg    <= 1'b0;
            headers_seen_reg  <= '0;
            m_valid_reg       <= 1'b0;
        end else begin
            if (cfg_we) begin
                max_headers_reg <= cfg_wdata;
            end
            phase_reg         <= phase_next;
            byte_offset_reg   <= byte_offset_next;
            line_start_reg    <= line_start_next;
            method_accum_reg  <= method_accum_next;
            method_len_reg    <= method_len_next;
            version_accum_reg <= version_accum_next;
            version_len_reg   <= version_len_next;
            token_count_reg   <= token_count_next;
            in_token_reg      <= in_token_next;
            held_method_reg   <= held_method_next;
            route_start_reg   <= route_start_next;
            route_length_reg  <= route_length_next;
            line_len_reg      <= line_len_next;
            key_length_reg    <= key_length_next;
            val_len_reg       <= val_len_next;
            colon_seen_reg    <= colon_seen_next;
            skip_left_reg     <= skip_left_next;
            line_begun_reg    <= line_begun_next;
            headers_seen_reg  <= headers_seen_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // Result payload loads only when a result is produced.
    always_ff @(posedge aclk) begin
        if (accept && emit) begin
            m_data_reg <= m_data_next;
        end
    end

endmodule
